// ===== rtl/core/pufp_pkg.sv =====
// ----------------------------------------------------------------------------
// pufp_pkg
// Shared types and constants for the phase unwrapper: port widths, command
// codes, controller states and the control/status bundles.
// ----------------------------------------------------------------------------
package pufp_pkg;

    // Fixed port widths
    localparam int PH_IN_W = 16;   // phase input port
    localparam int IDX_W   = 10;   // read_index and pivot_index ports
    localparam int OUT_W   = 28;   // unwrapped_phase port

    // Command codes on the cmd port
    localparam logic CMD_LOAD = 1'b0;
    localparam logic CMD_READ = 1'b1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_READ,
        ST_UP,
        ST_DOWN,
        ST_DRAIN
    } pufp_state_t;

    // Controller -> datapath commands
    typedef struct packed {
        logic load;        // store one sample
        logic pass_start;  // frame closed, latch length and pivot
        logic read;        // latch read index, range check
        logic read_out;    // register read result and strobe it
        logic issue;       // issue one raw read of the unwrap walk
        logic down;        // walk direction is downward
        logic turn_down;   // last upward read, restart at the pivot
    } pufp_ctl_t;

    // Datapath -> controller status
    typedef struct packed {
        logic at_last;     // walk address is frame_length-1
        logic at_zero;     // walk address is 0
        logic pipe_busy;   // unwrap pipeline still holds samples
    } pufp_sts_t;

endpackage

// ===== rtl/core/pufp_ram.sv =====
// ----------------------------------------------------------------------------
// pufp_ram
// Simple dual-port RAM: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module pufp_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ===== rtl/core/pufp_ctrl.sv =====
// ----------------------------------------------------------------------------
// pufp_ctrl
// Sequencer: accepts load/read commands, runs the upward and downward unwrap
// walks and drains the datapath pipeline before going idle.
// ----------------------------------------------------------------------------
module pufp_ctrl
    import pufp_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      start,
    input  logic      cmd,
    input  logic      last,
    output logic      busy,
    output pufp_ctl_t ctl,
    input  pufp_sts_t sts
);

    pufp_state_t state_reg;
    pufp_state_t state_next;
    logic        accept;

    assign accept = start && (state_reg == ST_IDLE);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    if (cmd == CMD_READ)
                    begin
                        state_next = ST_READ;
                    end
                    else if (last)
                    begin
                        state_next = ST_UP;
                    end
                end
            end
            ST_READ:
            begin
                state_next = ST_IDLE;
            end
            ST_UP:
            begin
                if (sts.at_last)
                begin
                    state_next = ST_DOWN;
                end
            end
            ST_DOWN:
            begin
                if (sts.at_zero)
                begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN:
            begin
                if (!sts.pipe_busy)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Outputs
    always_comb
    begin
        ctl  = '0;
        busy = 1'b1;
        unique case (state_reg)
            ST_IDLE:
            begin
                busy           = 1'b0;
                ctl.load       = accept && (cmd == CMD_LOAD);
                ctl.pass_start = accept && (cmd == CMD_LOAD) && last;
                ctl.read       = accept && (cmd == CMD_READ);
            end
            ST_READ:
            begin
                ctl.read_out = 1'b1;
            end
            ST_UP:
            begin
                ctl.issue     = 1'b1;
                ctl.turn_down = sts.at_last;
            end
            ST_DOWN:
            begin
                ctl.issue = 1'b1;
                ctl.down  = 1'b1;
            end
            ST_DRAIN:
            begin
                busy = 1'b1;
            end
            default:
            begin
                busy = 1'b1;
            end
        endcase
    end

endmodule

// ===== rtl/core/pufp_dp.sv =====
// ----------------------------------------------------------------------------
// pufp_dp
// Datapath: raw and unwrapped sample memories, frame counters, walk address,
// two-stage jump detect / wrap accumulate pipeline and read result registers.
// ----------------------------------------------------------------------------
module pufp_dp
    import pufp_pkg::*;
#(
    parameter int MAX_SAMPLES = 1024,
    parameter int PHASE_BITS  = 16
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  pufp_ctl_t               ctl,
    output pufp_sts_t               sts,
    input  logic                    pivot_we,
    input  logic [IDX_W-1:0]        pivot_index,
    input  logic [PH_IN_W-1:0]      phase,
    input  logic [IDX_W-1:0]        read_index,
    output logic signed [OUT_W-1:0] unwrapped_phase,
    output logic                    out_of_range,
    output logic                    done
);

    localparam int AW   = $clog2(MAX_SAMPLES);
    localparam int LW   = $clog2(MAX_SAMPLES + 1);
    localparam int CW   = (LW > IDX_W) ? LW : IDX_W;
    localparam int NW   = AW + 2;
    localparam int IN_W = (PHASE_BITS < PH_IN_W) ? PHASE_BITS : PH_IN_W;
    localparam int PB   = PHASE_BITS;

    // 0.9 turn scaled by ten: 9 * 2^PB
    localparam logic signed [PB+4:0] LIMIT = {5'b01001, {PB{1'b0}}};

    // Frame and configuration state
    logic [IDX_W-1:0] pivot_index_reg;
    logic [LW-1:0]    load_count_reg;
    logic [LW-1:0]    frame_length_reg;
    logic [AW-1:0]    pivot_reg;
    logic [AW-1:0]    addr_reg;
    logic             first_reg;

    // Pipeline
    logic             a_valid_reg;
    logic             a_first_reg;
    logic [AW-1:0]    a_addr_reg;
    logic [PB-1:0]    ref_reg;
    logic             b_valid_reg;
    logic             b_first_reg;
    logic [AW-1:0]    b_addr_reg;
    logic [PB-1:0]    b_cur_reg;
    logic             b_up_reg;
    logic             b_dn_reg;
    logic signed [NW-1:0] wrap_count_reg;
    logic signed [NW-1:0] wrap_count_next;

    // Read result
    logic             oor_reg;
    logic [OUT_W-1:0] unwrapped_phase_reg;
    logic             out_of_range_reg;
    logic             done_reg;

    // Combinational
    logic             room;
    logic [LW-1:0]    len_new;
    logic [CW-1:0]    piv_clamped;
    logic [PB-1:0]    sample;
    logic [PB-1:0]    raw_q;
    logic [OUT_W-1:0] unw_q;
    logic signed [PB:0]   diff;
    logic signed [PB+4:0] diff_ext;
    logic signed [PB+4:0] diff10;
    logic             step_up;
    logic             step_dn;
    logic [OUT_W-1:0] unw_wdata;

    assign room    = (load_count_reg < LW'(MAX_SAMPLES));
    assign len_new = room ? (load_count_reg + LW'(1)) : load_count_reg;
    assign sample  = PB'(phase[IN_W-1:0]);

    always_comb
    begin
        if (CW'(pivot_index_reg) >= CW'(len_new))
        begin
            piv_clamped = CW'(len_new - LW'(1));
        end
        else
        begin
            piv_clamped = CW'(pivot_index_reg);
        end
    end

    pufp_ram #(
        .WIDTH (PB),
        .DEPTH (MAX_SAMPLES)
    ) u_raw_ram (
        .clk   (clk),
        .we    (ctl.load && room),
        .waddr (load_count_reg[AW-1:0]),
        .wdata (sample),
        .raddr (addr_reg),
        .rdata (raw_q)
    );

    // Jump detect: 10*diff against +/- 9 * 2^PB
    assign diff     = $signed({1'b0, raw_q}) - $signed({1'b0, ref_reg});
    assign diff_ext = {{4{diff[PB]}}, diff};
    assign diff10   = (diff_ext <<< 3) + (diff_ext <<< 1);
    assign step_dn  = (diff10 > LIMIT);
    assign step_up  = (diff10 < -LIMIT);

    always_comb
    begin
        if (b_first_reg)
        begin
            wrap_count_next = '0;
        end
        else if (b_up_reg)
        begin
            wrap_count_next = wrap_count_reg + NW'(1);
        end
        else if (b_dn_reg)
        begin
            wrap_count_next = wrap_count_reg - NW'(1);
        end
        else
        begin
            wrap_count_next = wrap_count_reg;
        end
    end

    assign unw_wdata = OUT_W'(b_cur_reg) + (OUT_W'(wrap_count_next) << PB);

    pufp_ram #(
        .WIDTH (OUT_W),
        .DEPTH (MAX_SAMPLES)
    ) u_unw_ram (
        .clk   (clk),
        .we    (b_valid_reg),
        .waddr (b_addr_reg),
        .wdata (unw_wdata),
        .raddr (AW'(read_index)),
        .rdata (unw_q)
    );

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pivot_index_reg  <= '0;
            load_count_reg   <= '0;
            frame_length_reg <= '0;
            first_reg        <= 1'b0;
            a_valid_reg      <= 1'b0;
            b_valid_reg      <= 1'b0;
            wrap_count_reg   <= '0;
            done_reg         <= 1'b0;
        end
        else
        begin
            if (pivot_we)
            begin
                pivot_index_reg <= pivot_index;
            end
            if (ctl.pass_start)
            begin
                load_count_reg   <= '0;
                frame_length_reg <= len_new;
            end
            else if (ctl.load && room)
            begin
                load_count_reg <= load_count_reg + LW'(1);
            end
            if (ctl.pass_start || ctl.turn_down)
            begin
                first_reg <= 1'b1;
            end
            else if (ctl.issue)
            begin
                first_reg <= 1'b0;
            end
            a_valid_reg <= ctl.issue;
            b_valid_reg <= a_valid_reg;
            if (b_valid_reg)
            begin
                wrap_count_reg <= wrap_count_next;
            end
            done_reg <= ctl.read_out;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (ctl.pass_start)
        begin
            pivot_reg <= AW'(piv_clamped);
            addr_reg  <= AW'(piv_clamped);
        end
        else if (ctl.turn_down)
        begin
            addr_reg <= pivot_reg;
        end
        else if (ctl.issue)
        begin
            addr_reg <= ctl.down ? (addr_reg - AW'(1)) : (addr_reg + AW'(1));
        end

        a_first_reg <= first_reg;
        a_addr_reg  <= addr_reg;

        if (a_valid_reg)
        begin
            ref_reg <= raw_q;
        end
        b_first_reg <= a_first_reg;
        b_addr_reg  <= a_addr_reg;
        b_cur_reg   <= raw_q;
        b_up_reg    <= step_up && !a_first_reg;
        b_dn_reg    <= step_dn && !a_first_reg;

        if (ctl.read)
        begin
            oor_reg <= (CW'(read_index) >= CW'(frame_length_reg));
        end
        if (ctl.read_out)
        begin
            unwrapped_phase_reg <= oor_reg ? '0 : unw_q;
            out_of_range_reg    <= oor_reg;
        end
    end

    assign sts.at_last   = (LW'(addr_reg) == (frame_length_reg - LW'(1)));
    assign sts.at_zero   = (addr_reg == '0);
    assign sts.pipe_busy = a_valid_reg || b_valid_reg;

    assign unwrapped_phase = $signed(unwrapped_phase_reg);
    assign out_of_range    = out_of_range_reg;
    assign done            = done_reg;

endmodule

// ===== rtl/core/phase_unwrap_from_pivot.sv =====
// ----------------------------------------------------------------------------
// phase_unwrap_from_pivot
// 1-D phase unwrapper that walks outward from a programmable pivot sample.
// ----------------------------------------------------------------------------
// Usage:
//   Command channel: a transfer happens on a rising edge with start high and
//   busy low. cmd = load stores phase as the next sample of the frame; with
//   last high it closes the frame and starts the unwrap pass. cmd = read
//   fetches the unwrapped value at read_index.
//   Result channel: for each read, done pulses for one cycle with
//   unwrapped_phase (turn/2^PHASE_BITS units, two's complement) and
//   out_of_range (index at or past the frame length; value is then 0).
//   Loads give no result. The receiver cannot stall; done is not held.
//   Timing: loads run back to back. A read passes through the READ state,
//   which keeps busy high; the result and done are registered from that
//   state, and a new read is taken only once busy drops. The closing load
//   keeps busy high for the whole pass: one raw-memory read per sample from
//   the pivot up to the end and from the pivot down to 0 (the pivot is read
//   on both walks), then a drain of the two-stage pipeline. The single read
//   port of the raw sample memory sets the length of the pass.
//   pivot_we writes pivot_index; write it only while idle.
//   Reset clears the frame counters, the pivot and the wrap count. Both
//   memories are left uninitialized; reads only reach entries written by
//   the last pass, and the previous frame stays readable while a new one loads.
// ----------------------------------------------------------------------------
module phase_unwrap_from_pivot
    import pufp_pkg::*;
#(
    parameter int MAX_SAMPLES = 1024,
    parameter int PHASE_BITS  = 16
) (
    input  logic                    clk,
    input  logic                    rst_n,
    // command channel
    input  logic                    start,
    output logic                    busy,
    input  logic                    cmd,
    input  logic [PH_IN_W-1:0]      phase,
    input  logic                    last,
    input  logic [IDX_W-1:0]        read_index,
    // result channel
    output logic                    done,
    output logic signed [OUT_W-1:0] unwrapped_phase,
    output logic                    out_of_range,
    // configuration
    input  logic                    pivot_we,
    input  logic [IDX_W-1:0]        pivot_index
);

    pufp_ctl_t ctl;
    pufp_sts_t sts;

    // Sequencer: command decode, upward walk, downward walk, drain
    pufp_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .cmd   (cmd),
        .last  (last),
        .busy  (busy),
        .ctl   (ctl),
        .sts   (sts)
    );

    // Memories, counters, jump detection and wrap accumulation
    pufp_dp #(
        .MAX_SAMPLES (MAX_SAMPLES),
        .PHASE_BITS  (PHASE_BITS)
    ) u_dp (
        .clk             (clk),
        .rst_n           (rst_n),
        .ctl             (ctl),
        .sts             (sts),
        .pivot_we        (pivot_we),
        .pivot_index     (pivot_index),
        .phase           (phase),
        .read_index      (read_index),
        .unwrapped_phase (unwrapped_phase),
        .out_of_range    (out_of_range),
        .done            (done)
    );

endmodule

// ===== sim/phase_unwrap_from_pivot_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// phase_unwrap_from_pivot_tb
// Self-checking bench for the pivot-based phase unwrapper. Frames of wrapped
// phase samples are loaded through the command channel, reads are checked
// against an in-bench prediction of the unwrap pass, and the pivot register
// is moved between frames while the block is idle.
// ----------------------------------------------------------------------------
module phase_unwrap_from_pivot_tb
    import pufp_pkg::*;
();

    localparam int MAX_SAMPLES    = 1024;
    localparam int TURN           = 1 << 16;     // one full turn in phase units
    localparam int JUMP_LIM       = 9 * TURN;    // 10*diff must exceed this to wrap
    localparam int JUMP_MIN       = 58983;       // smallest step that counts as a wrap
    localparam int PASS_SLACK     = 3 + 16;      // pass overhead plus margin
    localparam int RANDOM_ITEMS   = 100;
    localparam int CALM_ITEMS     = 30;          // tail of the run without gaps
    localparam int WATCHDOG_LIMIT = 10000;

    typedef struct {
        logic signed [OUT_W-1:0] value;
        logic                    oor;
    } read_result_t;

    // Sample shapes used to build frames
    typedef enum {
        SHAPE_WALK,    // bounded random walk, wraps when it crosses zero
        SHAPE_EDGE,    // steps near the 0.9 turn threshold
        SHAPE_NOISE    // uniform random samples
    } frame_shape_t;

    logic                    clk;
    logic                    rst_n;
    logic                    start;
    logic                    busy;
    logic                    cmd;
    logic [PH_IN_W-1:0]      phase;
    logic                    last;
    logic [IDX_W-1:0]        read_index;
    logic                    done;
    logic signed [OUT_W-1:0] unwrapped_phase;
    logic                    out_of_range;
    logic                    pivot_we;
    logic [IDX_W-1:0]        pivot_index;

    // Shadow of the block's state, kept in step with each accepted transfer
    logic [PH_IN_W-1:0]      raw_samples       [0:MAX_SAMPLES-1];
    logic signed [OUT_W-1:0] unwrapped_samples [0:MAX_SAMPLES-1];
    int unsigned             fill_count;
    int unsigned             frame_len;
    logic [IDX_W-1:0]        pivot_sel;

    read_result_t            pending_reads[$];
    read_result_t            want;
    int                      fail_count;
    int                      sent_count;
    int                      idle_cycles;
    bit                      gaps_on;

    phase_unwrap_from_pivot dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .start          (start),
        .busy           (busy),
        .cmd            (cmd),
        .phase          (phase),
        .last           (last),
        .read_index     (read_index),
        .done           (done),
        .unwrapped_phase(unwrapped_phase),
        .out_of_range   (out_of_range),
        .pivot_we       (pivot_we),
        .pivot_index    (pivot_index)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // ------------------------------------------------------------------------
    // Command transfer plus prediction. Start is left high on return so that
    // back-to-back transfers never drop it; anything that waits must call
    // go_idle first.
    // ------------------------------------------------------------------------
    task automatic transfer_cmd(input logic op, input logic [PH_IN_W-1:0] ph,
                                input logic lst, input logic [IDX_W-1:0] idx);
        int           gap;
        int unsigned  p;
        int unsigned  i;
        int           wraps;
        int           prior;
        int           cur;
        int           diff;
        read_result_t r;
        if (gaps_on && $urandom_range(0, 3) == 0)
        begin
            gap = $urandom_range(1, 8);
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        start      <= 1'b1;
        cmd        <= op;
        phase      <= ph;
        last       <= lst;
        read_index <= idx;
        @(posedge clk);
        while (busy) @(posedge clk);
        sent_count++;

        if (op == CMD_LOAD)
        begin
            // samples past the frame capacity are dropped, last still closes
            if (fill_count < MAX_SAMPLES)
            begin
                raw_samples[fill_count] = ph;
                fill_count++;
            end
            if (lst)
            begin
                frame_len  = fill_count;
                fill_count = 0;
                p = (pivot_sel > frame_len - 1) ? frame_len - 1 : pivot_sel;
                unwrapped_samples[p] = OUT_W'(raw_samples[p]);
                // upward from the pivot: a rising jump means we wrapped down
                wraps = 0;
                prior = raw_samples[p];
                for (i = p + 1; i < frame_len; i++)
                begin
                    cur  = raw_samples[i];
                    diff = cur - prior;
                    if (10 * diff > JUMP_LIM)
                        wraps--;
                    if (10 * diff < -JUMP_LIM)
                        wraps++;
                    unwrapped_samples[i] = OUT_W'(cur + wraps * TURN);
                    prior = cur;
                end
                // downward from the pivot, mirror image of the above
                wraps = 0;
                prior = raw_samples[p];
                for (i = p; i > 0; i--)
                begin
                    cur  = raw_samples[i - 1];
                    diff = prior - cur;
                    if (10 * diff > JUMP_LIM)
                        wraps++;
                    if (10 * diff < -JUMP_LIM)
                        wraps--;
                    unwrapped_samples[i - 1] = OUT_W'(cur + wraps * TURN);
                    prior = cur;
                end
            end
        end
        else
        begin
            // previous frame stays readable while a new one loads
            if (idx >= frame_len)
            begin
                r.value = '0;
                r.oor   = 1'b1;
            end
            else
            begin
                r.value = unwrapped_samples[idx];
                r.oor   = 1'b0;
            end
            pending_reads.push_back(r);
        end
    endtask

    // read_index is don't-care on loads, phase/last on reads: keep them random
    task automatic load_sample(input logic [PH_IN_W-1:0] ph, input logic lst);
        transfer_cmd(CMD_LOAD, ph, lst, IDX_W'($urandom));
    endtask

    task automatic read_at(input logic [IDX_W-1:0] idx);
        transfer_cmd(CMD_READ, PH_IN_W'($urandom), 1'($urandom), idx);
    endtask

    // Drop start, let all reads return, then cover the longest possible pass
    task automatic go_idle();
        start <= 1'b0;
        @(posedge clk);
        while (pending_reads.size() != 0) @(posedge clk);
        repeat (frame_len + PASS_SLACK) @(posedge clk);
    endtask

    task automatic write_pivot(input logic [IDX_W-1:0] value);
        go_idle();
        pivot_we    <= 1'b1;
        pivot_index <= value;
        @(posedge clk);
        pivot_we    <= 1'b0;
        pivot_sel    = value;
    endtask

    function automatic logic [PH_IN_W-1:0] next_phase(input logic [PH_IN_W-1:0] prev,
                                                      input frame_shape_t shape);
        int unsigned step;
        case (shape)
            SHAPE_WALK: step = $urandom_range(0, 24000);
            SHAPE_EDGE: step = ($urandom_range(0, 2) == 0) ? $urandom_range(0, 4000)
                                                           : $urandom_range(JUMP_MIN - 3,
                                                                            JUMP_MIN + 3);
            default:    return PH_IN_W'($urandom);
        endcase
        return $urandom_range(0, 1) ? prev + PH_IN_W'(step) : prev - PH_IN_W'(step);
    endfunction

    // ------------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------------

    // No frame yet: every index is out of range
    task automatic test_read_before_frame();
        read_at('0);
        read_at('1);
    endtask

    // Pivot at 0, steps right on both sides of the threshold, wrap both ways
    task automatic test_threshold_steps();
        write_pivot('0);
        load_sample(16'd0, 1'b0);
        load_sample(16'(JUMP_MIN), 1'b0);      // just wraps
        load_sample(16'd1, 1'b0);              // one short of a wrap
        load_sample(16'hFFFF, 1'b0);
        load_sample(16'd0, 1'b1);              // full-scale step back
        read_at(10'd0);
        read_at(10'd4);
        read_at(10'd5);                        // first index past the frame
    endtask

    // Pivot far past the frame end gets clamped; reads mid-load see old frame
    task automatic test_pivot_clamp();
        write_pivot('1);
        load_sample(16'd65000, 1'b0);
        load_sample(16'd100, 1'b0);
        read_at(10'd2);
        load_sample(16'd30000, 1'b0);
        load_sample(16'd65500, 1'b1);
        read_at(10'd0);
        read_at(10'd3);
    endtask

    // One-sample frame: pivot clamps to 0, value passes straight through
    task automatic test_single_sample();
        load_sample(16'd40000, 1'b1);
        read_at(10'd0);
        read_at(10'd1);
    endtask

    // More samples than the store holds; last arrives on a dropped sample
    task automatic test_frame_overflow();
        logic [PH_IN_W-1:0] ph;
        int                 k;
        write_pivot(10'd512);
        ph = PH_IN_W'($urandom);
        for (k = 0; k < MAX_SAMPLES + 6; k++)
        begin
            ph = next_phase(ph, SHAPE_WALK);
            load_sample(ph, k == MAX_SAMPLES + 5);
        end
        read_at('1);
        read_at('0);
        read_at(10'd512);
        read_at(IDX_W'($urandom));
    endtask

    // Random frames: mostly short, occasionally long, pivot moved now and then
    task automatic test_random_frames();
        int                 base;
        int                 len;
        int                 k;
        int                 pick;
        bit                 calm;
        frame_shape_t       shape;
        logic [PH_IN_W-1:0] ph;
        base = sent_count;
        while (sent_count - base < RANDOM_ITEMS)
        begin
            // stretches with and without gaps; none near the end
            calm    = (sent_count - base >= RANDOM_ITEMS - CALM_ITEMS);
            gaps_on = !calm && ($urandom_range(0, 2) != 0);
            if (!calm && $urandom_range(0, 4) == 0)
            begin
                pick = $urandom_range(0, 3);
                case (pick)
                    0:       write_pivot('0);
                    1:       write_pivot('1);
                    2:       write_pivot(IDX_W'($urandom_range(0, 63)));
                    default: write_pivot(IDX_W'($urandom));
                endcase
            end
            pick = $urandom_range(0, 99);
            if (pick < 75)
                len = $urandom_range(1, 40);
            else if (pick < 95)
                len = $urandom_range(41, 200);
            else
                len = $urandom_range(201, 700);
            // keep the item count near its budget
            if (len > RANDOM_ITEMS - (sent_count - base))
                len = RANDOM_ITEMS - (sent_count - base);
            pick  = $urandom_range(0, 9);
            shape = (pick < 6) ? SHAPE_WALK : (pick < 9) ? SHAPE_EDGE : SHAPE_NOISE;
            ph    = PH_IN_W'($urandom);
            for (k = 0; k < len; k++)
            begin
                ph = next_phase(ph, shape);
                load_sample(ph, k == len - 1);
                if (k != len - 1 && $urandom_range(0, 7) == 0)
                    read_at(IDX_W'($urandom_range(0, 63)));
            end
            for (k = $urandom_range(1, 6); k > 0; k--)
            begin
                if ($urandom_range(0, 4) == 0)
                    read_at(IDX_W'($urandom));
                else
                    read_at(IDX_W'($urandom_range(0, frame_len - 1)));
            end
        end
    endtask

    // ------------------------------------------------------------------------
    // Result check: done is a one-cycle strobe, sampled at the edge ending it
    // ------------------------------------------------------------------------
    always @(posedge clk)
    begin
        if (rst_n && done)
        begin
            if (pending_reads.size() == 0)
            begin
                $error("unexpected result: unwrapped_phase=%0d out_of_range=%0b",
                       unwrapped_phase, out_of_range);
                fail_count++;
            end
            else
            begin
                want = pending_reads.pop_front();
                if (unwrapped_phase !== want.value)
                begin
                    $error("unwrapped_phase: expected %0d, got %0d",
                           want.value, unwrapped_phase);
                    fail_count++;
                end
                if (out_of_range !== want.oor)
                begin
                    $error("out_of_range: expected %0b, got %0b", want.oor, out_of_range);
                    fail_count++;
                end
            end
        end
    end

    // Watchdog: any transfer on either channel resets the count
    always @(posedge clk)
    begin
        if (!rst_n || (start && !busy) || done)
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $error("watchdog: no transfer for %0d cycles", idle_cycles);
            $display("** phase_unwrap_from_pivot: FAILED **");
            $finish;
        end
    end

    initial
    begin
        rst_n       <= 1'b0;
        start       <= 1'b0;
        cmd         <= CMD_LOAD;
        phase       <= '0;
        last        <= 1'b0;
        read_index  <= '0;
        pivot_we    <= 1'b0;
        pivot_index <= '0;
        fail_count   = 0;
        sent_count   = 0;
        idle_cycles  = 0;
        fill_count   = 0;
        frame_len    = 0;
        pivot_sel    = '0;
        gaps_on      = 1'b1;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_read_before_frame();
        test_threshold_steps();
        test_pivot_clamp();
        test_single_sample();
        test_frame_overflow();
        test_random_frames();

        go_idle();
        if (fail_count == 0)
            $display("** phase_unwrap_from_pivot: PASSED **");
        else
            $display("** phase_unwrap_from_pivot: FAILED **");
        $finish;
    end

endmodule
